// File: src/bcd_pkg.sv
// Shared types, codes and helpers for the button click detector.
`timescale 1ns / 1ps
package bcd_pkg;

   localparam int unsigned TIMER_W = 8;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef logic [TIMER_W-1:0] timer_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_CLICK_WINDOW = 1'b1;

   localparam timer_type LONG_PRESS_TICKS_RESET    = 8'd15;
   localparam timer_type DOUBLE_CLICK_WINDOW_RESET = 8'd3;
   localparam timer_type TIMER_MAX                 = 8'hFF;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_CONFIRM = 4'b0010,
      PH_HOLD    = 4'b0100,
      PH_WAIT    = 4'b1000
   } press_phase_type;

   typedef enum logic [1:0] {
      CK_IDLE = 2'b01,
      CK_HELD = 2'b10
   } click_phase_type;

   // One accepted item as seen by the state machines
   typedef struct packed {
      logic fire;
      logic tick;
      logic down;
   } step_type;

   function automatic timer_type sat_inc(input timer_type v);
      sat_inc = (v == TIMER_MAX) ? v : v + timer_type'(1);
   endfunction

endpackage

// File: src/bcd_press.sv
// Press machine: confirms a press, times the hold, reports click or long press.
`timescale 1ns / 1ps
module bcd_press (
   input  logic                clock,
   input  logic                reset,
   input  bcd_pkg::step_type   step,
   input  bcd_pkg::timer_type  long_press_ticks,
   output bcd_pkg::event_type  press_event
);
   import bcd_pkg::*;

   press_phase_type phase_ff, phase_in;
   timer_type       hold_ff, hold_in;

   always_comb begin
      phase_in    = phase_ff;
      hold_in     = hold_ff;
      press_event = EV_NONE;
      if (step.fire) begin
         if (step.tick) begin
            hold_in = sat_inc(hold_ff);
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (step.down) phase_in = PH_CONFIRM;
               end
               PH_CONFIRM: begin
                  if (step.down) begin
                     hold_in  = '0;
                     phase_in = PH_HOLD;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_HOLD: begin
                  if (!step.down) begin
                     press_event = EV_CLICK;
                     phase_in    = PH_IDLE;
                  end else if (hold_ff >= long_press_ticks) begin
                     press_event = EV_LONG;
                     phase_in    = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  if (!step.down) phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// File: src/bcd_click.sv
// Click stage: holds back a first click, merges a second into a double click.
`timescale 1ns / 1ps
module bcd_click (
   input  logic                clock,
   input  logic                reset,
   input  bcd_pkg::step_type   step,
   input  bcd_pkg::event_type  press_event,
   input  bcd_pkg::timer_type  double_click_window,
   output bcd_pkg::event_type  click_event
);
   import bcd_pkg::*;

   click_phase_type phase_ff, phase_in;
   timer_type       window_ff, window_in;

   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      click_event = EV_NONE;
      if (step.fire) begin
         if (step.tick) begin
            window_in = sat_inc(window_ff);
         end else begin
            case (phase_ff)
               CK_IDLE: begin
                  if (press_event == EV_CLICK) begin
                     window_in = '0;
                     phase_in  = CK_HELD;
                  end else begin
                     click_event = press_event;
                  end
               end
               CK_HELD: begin
                  // a long press here is dropped
                  if (press_event == EV_CLICK) begin
                     click_event = EV_DOUBLE;
                     phase_in    = CK_IDLE;
                  end else if (window_ff > double_click_window) begin
                     click_event = EV_CLICK;
                     phase_in    = CK_IDLE;
                  end
               end
               default: begin
                  phase_in = CK_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= CK_IDLE;
         window_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
      end
   end

endmodule

// File: src/bcd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module bcd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bcd_pkg::event_type  push_event,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output bcd_pkg::event_type  out_event
);
   import bcd_pkg::*;

   logic      head_valid_ff, head_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   event_type head_ff, head_in;
   event_type skid_ff, skid_in;
   logic      pop;

   assign pop       = head_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_event = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // full: no push can arrive
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (head_valid_ff && !pop && push) begin
         skid_in       = push_event;
         skid_valid_in = 1'b1;
      end else begin
         head_valid_in = push || (head_valid_ff && !pop);
         if (push) head_in = push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// File: src/button_click_double_long_detector_core.sv
// Top level of the push-button click, double click and long press detector.
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_command, req_button_down
// rsp_      out        rsp_valid/rsp_stall  rsp_event_code
// csr_      in         csr_write            csr_index, csr_data
//
// One item is taken per clock while req_stall is low, and each yields exactly
// one result item, registered in the output or, behind a waiting one, the skid
// register. Press and click machines feed back on themselves and set the rate.
// Reset is synchronous: both machines go idle, both timers clear, the
// registers return to 15 and 3, and the result buffer empties.
// The result buffer holds two items, so req_stall rises only when a result is
// waiting in the output register and a second one sits in the skid register.
`timescale 1ns / 1ps
module button_click_double_long_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic                                req_button_down,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_event_code,
   input  logic                                csr_write,
   input  logic [bcd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bcd_pkg::TIMER_W-1:0]         csr_data
);
   import bcd_pkg::*;

   timer_type long_press_ticks_ff;
   timer_type double_click_window_ff;
   step_type  step;
   event_type press_event;
   event_type click_event;
   event_type out_event;
   logic      buf_full;

   // Hold configuration; user writes only while the block is idle, not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ticks_ff    <= LONG_PRESS_TICKS_RESET;
         double_click_window_ff <= DOUBLE_CLICK_WINDOW_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LONG_PRESS_TICKS:    long_press_ticks_ff    <= csr_data;
            CSR_DOUBLE_CLICK_WINDOW: double_click_window_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Accept an item whenever the result buffer has room
   assign req_stall = buf_full;
   assign step.fire = req_valid && !req_stall;
   assign step.tick = req_command;
   assign step.down = req_button_down;

   bcd_press u_press (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .long_press_ticks (long_press_ticks_ff),
      .press_event      (press_event)
   );

   // Chain the press event straight into the click stage, same cycle
   bcd_click u_click (
      .clock               (clock),
      .reset               (reset),
      .step                (step),
      .press_event         (press_event),
      .double_click_window (double_click_window_ff),
      .click_event         (click_event)
   );

   // Register the result; a timer tick always gives no event
   bcd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (step.fire),
      .push_event (click_event),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_event  (out_event)
   );

   assign rsp_event_code = out_event;

endmodule

// File: src/bcd_checker.sv
// Port-level checker for the button detector, bound to the top level.
`timescale 1ns / 1ps
module bcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_code
);
   import bcd_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_event_code)))
      else $error("stalled result item changed or vanished");

   // Reset leaves the result buffer empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // A tick into an empty buffer gives a no-event result next cycle
   a_tick_none: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command && !rsp_valid)
      |=> (rsp_valid && rsp_event_code == EV_NONE))
      else $error("timer tick did not give a no-event result");

endmodule

bind button_click_double_long_detector_core bcd_checker u_bcd_checker (.*);

// File: tb/button_event_checker.sv
// Checker for the button detector: predicts each result item and compares it.
`timescale 1ns / 1ps
module button_event_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic                            req_button_down,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_event_code,
   input  logic                            csr_write,
   input  logic [bcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcd_pkg::TIMER_W-1:0]     csr_data,
   output int                              fail_count,
   output int                              pending
);
   import bcd_pkg::*;

   timer_type       long_limit;
   timer_type       window_limit;
   press_phase_type press_st;
   click_phase_type click_st;
   timer_type       hold_cnt;
   timer_type       window_cnt;
   event_type       expected_events[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic event_type press_step(input logic down);
      event_type ev;
      ev = EV_NONE;
      case (press_st)
         PH_IDLE: begin
            if (down) press_st = PH_CONFIRM;
         end
         PH_CONFIRM: begin
            if (down) begin
               hold_cnt = '0;
               press_st = PH_HOLD;
            end else begin
               press_st = PH_IDLE;
            end
         end
         PH_HOLD: begin
            if (!down) begin
               ev       = EV_CLICK;
               press_st = PH_IDLE;
            end else if (hold_cnt >= long_limit) begin
               ev       = EV_LONG;
               press_st = PH_WAIT;
            end
         end
         default: begin
            if (!down) press_st = PH_IDLE;
         end
      endcase
      return ev;
   endfunction

   // Hold back a first click; a second click makes a double, expiry a single.
   function automatic event_type click_step(input event_type ev);
      event_type res;
      res = EV_NONE;
      if (click_st == CK_IDLE) begin
         if (ev == EV_CLICK) begin
            window_cnt = '0;
            click_st   = CK_HELD;
         end else begin
            res = ev;
         end
      end else if (ev == EV_CLICK) begin
         res      = EV_DOUBLE;
         click_st = CK_IDLE;
      end else if (window_cnt > window_limit) begin
         res      = EV_CLICK;
         click_st = CK_IDLE;
      end
      return res;
   endfunction

   function automatic event_type predict_event(input logic tick, input logic down);
      if (tick) begin
         if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
         if (window_cnt != '1) window_cnt = window_cnt + 1'b1;
         return EV_NONE;
      end
      return click_step(press_step(down));
   endfunction

   always @(posedge clock) begin
      event_type want;
      if (reset) begin
         long_limit   = LONG_PRESS_TICKS_RESET;
         window_limit = DOUBLE_CLICK_WINDOW_RESET;
         press_st     = PH_IDLE;
         click_st     = CK_IDLE;
         hold_cnt     = '0;
         window_cnt   = '0;
         expected_events.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LONG_PRESS_TICKS:    long_limit   = csr_data;
               CSR_DOUBLE_CLICK_WINDOW: window_limit = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_events.push_back(predict_event(req_command, req_button_down));
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual event_code %0d",
                        $time, rsp_event_code);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_code !== want) begin
                  $display("%0t: event_code mismatch, expected %0d, actual %0d",
                           $time, want, rsp_event_code);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_events.size();
   end

endmodule

// File: tb/tb_button_click_double_long_detector_core.sv
// Testbench top for the button detector: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_button_click_double_long_detector_core;
   import bcd_pkg::*;

   // Item kinds on the request channel
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Hard stop, far beyond the slowest correct run
   localparam int CYCLE_LIMIT = 400000;

   // Receiver behaviour, held for a random stretch of cycles
   typedef enum int {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_TOGGLE
   } flow_mode_type;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic                   req_command     = CMD_SCAN;
   logic                   req_button_down = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [1:0]             rsp_event_code;
   logic                   csr_write       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_LONG_PRESS_TICKS;
   logic [TIMER_W-1:0]     csr_data        = '0;

   int fail_count;
   int pending;

   int            cycle_count = 0;
   int            burst_left  = 0;
   int            items_sent  = 0;
   int            flow_left   = 0;
   flow_mode_type flow_mode   = FLOW_FREE;

   // Current settings, kept only to shape gestures around the limits
   int cur_ticks  = LONG_PRESS_TICKS_RESET;
   int cur_window = DOUBLE_CLICK_WINDOW_RESET;

   button_click_double_long_detector_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_button_down (req_button_down),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   button_event_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_button_down (req_button_down),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   always #10 clock = ~clock;

   // Abort the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: pick a stall pattern, hold it for a while, then pick another.
   // The free mode gives stretches with no back-pressure at all.
   always @(posedge clock) begin
      if (flow_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 3));
         flow_left = $urandom_range(10, 80);
      end
      flow_left--;
      case (flow_mode)
         FLOW_FREE:  rsp_stall <= 1'b0;
         FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= ~rsp_stall;
      endcase
   end

   // Offer one item and hold it until the block takes it. The sender runs in
   // bursts; at the start of a burst drop valid for a random gap, so gaps land
   // anywhere in a gesture. Valid stays high across back-to-back items.
   task automatic push_item(input logic cmd, input logic down);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_button_down <= down;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic scan(input logic down);
      push_item(CMD_SCAN, down);
   endtask

   // Timer ticks; the level bit is ignored on a tick, so randomise it
   task automatic tick_run(input int n);
      repeat (n) push_item(CMD_TICK, 1'($urandom_range(0, 1)));
   endtask

   // Drop valid and wait until every expected result item has come back
   task automatic drain;
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic apply_config(input int ticks, input int window);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_LONG_PRESS_TICKS;
      csr_data  <= TIMER_W'(ticks);
      @(posedge clock);
      csr_index <= CSR_DOUBLE_CLICK_WINDOW;
      csr_data  <= TIMER_W'(window);
      @(posedge clock);
      csr_write  <= 1'b0;
      cur_ticks  = ticks;
      cur_window = window;
   endtask

   // Confirmed press, a short hold below the limit, then release
   task automatic click;
      int hold;
      hold = (cur_ticks > 1) ? $urandom_range(0, (cur_ticks - 1 < 4) ? cur_ticks - 1 : 4) : 0;
      scan(1'b1);
      scan(1'b1);
      tick_run(hold);
      if ($urandom_range(0, 1)) scan(1'b1);
      scan(1'b0);
      if ($urandom_range(0, 2) == 0) scan(1'b0);
   endtask

   // Hold past the limit, keep holding, then release
   task automatic long_press;
      scan(1'b1);
      scan(1'b1);
      tick_run(cur_ticks + $urandom_range(0, 2));
      repeat ($urandom_range(1, 3)) scan(1'b1);
      scan(1'b0);
   endtask

   task automatic double_click;
      click();
      tick_run($urandom_range(0, (cur_window < 6) ? cur_window : 6));
      click();
   endtask

   // Let the window run out; now and then run both timers into saturation
   task automatic expire_window;
      if ($urandom_range(0, 7) == 0)
         tick_run($urandom_range(256, 270));
      else
         tick_run(((cur_window < 255) ? cur_window + 1 : 8) + $urandom_range(0, 2));
      scan(1'b0);
   endtask

   // Unstructured items: bounce, stray ticks, broken presses
   task automatic noise;
      repeat ($urandom_range(1, 8))
         push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic random_phase(input int budget);
      int stop_at;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2: click();
            3, 4:    long_press();
            5:       expire_window();
            6, 7:    double_click();
            default: noise();
         endcase
      end
   endtask

   initial begin : stimulus
      int waited;
      waited = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings first, untouched
      random_phase(150);

      // Directed pass with a short hold limit and a tight window
      apply_config(2, 1);
      scan(1'b1);                          // bounce: confirm aborted
      scan(1'b0);
      scan(1'b1);                          // first click, held back
      scan(1'b1);
      scan(1'b0);
      scan(1'b1);                          // second click: double
      scan(1'b1);
      scan(1'b0);
      scan(1'b1);                          // long press, then wait for release
      scan(1'b1);
      tick_run(2);
      scan(1'b1);
      scan(1'b1);
      scan(1'b0);
      scan(1'b1);                          // click held back ...
      scan(1'b1);
      scan(1'b0);
      scan(1'b1);                          // ... long press dropped, click released
      scan(1'b1);
      tick_run(2);
      scan(1'b1);
      scan(1'b0);

      // Extremes of both registers, including a zero hold limit and a window
      // that never expires
      apply_config(1, 0);
      random_phase(200);
      apply_config(0, 255);
      random_phase(150);
      apply_config(255, 254);
      random_phase(300);
      repeat (3) begin
         apply_config($urandom_range(1, 40), $urandom_range(0, 20));
         random_phase(150);
      end
      apply_config(LONG_PRESS_TICKS_RESET, DOUBLE_CLICK_WINDOW_RESET);
      random_phase(100);

      // Drain, with a bound, then allow the pipeline to settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: button_click_double_long_detector_core.f
src/bcd_pkg.sv
src/bcd_press.sv
src/bcd_click.sv
src/bcd_out_buf.sv
src/button_click_double_long_detector_core.sv
src/bcd_checker.sv
tb/button_event_checker.sv
tb/tb_button_click_double_long_detector_core.sv
